>>> sv/cwm_pkg.sv
`default_nettype none

package cwm_pkg;

  // default mailbox size
  localparam int MailboxDepthDefault = 8;

  // item kinds
  localparam logic CmdChar = 1'b0;
  localparam logic CmdGet  = 1'b1;

  // word building
  localparam logic [7:0] EndMark = 8'h2A;
  localparam logic [3:0] OnLen   = 4'd6;
  localparam logic [3:0] OffLen  = 4'd7;
  localparam logic [3:0] LenMax  = 4'd15;

  // receiver and message codes
  localparam logic [1:0] RcvNone = 2'd0;
  localparam logic [1:0] RcvLed  = 2'd1;
  localparam logic [1:0] MsgNone = 2'd0;
  localparam logic [1:0] MsgOn   = 2'd1;
  localparam logic [1:0] MsgOff  = 2'd2;

  // slot entry as stored in the mailbox memory
  typedef struct packed {
    logic [1:0] rcv;
    logic [1:0] msg;
  } slot_t;

  // characters of LED_ON
  function automatic logic [7:0] on_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h4C;  // L
      4'd1:    c = 8'h45;  // E
      4'd2:    c = 8'h44;  // D
      4'd3:    c = 8'h5F;  // _
      4'd4:    c = 8'h4F;  // O
      4'd5:    c = 8'h4E;  // N
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // characters of LED_OFF
  function automatic logic [7:0] off_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h4C;  // L
      4'd1:    c = 8'h45;  // E
      4'd2:    c = 8'h44;  // D
      4'd3:    c = 8'h5F;  // _
      4'd4:    c = 8'h4F;  // O
      4'd5:    c = 8'h46;  // F
      4'd6:    c = 8'h46;  // F
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> sv/command_word_mailbox.sv
// Command word mailbox. Character requests (command=0) build a word that '*' ends; a finished
// word of exactly LED_ON or LED_OFF posts receiver 1 with message 1 or 2 into a ring of
// MAILBOX_DEPTH slots, overwriting whatever the slot at the write pointer holds. A character
// request gives no result. A retrieve request (command=1) scans the slot
// memory from slot 0, one slot per cycle through its single read port, returns the message of
// the first slot holding receiver_id (found=1) and clears it, or found=0 with message 0. A
// retrieve stops scanning at the first matching slot or after the last slot; the next request
// is taken once the result is in the output register, which holds it until out_ready. Slot
// contents come up as receiver 0 / message 0 after reset with no clearing pass.
`default_nettype none

module command_word_mailbox #(
  parameter int MAILBOX_DEPTH = cwm_pkg::MailboxDepthDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       command,
  input  wire logic [7:0] char_byte,
  input  wire logic [1:0] receiver_id,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            found,
  output logic [1:0]      message_code
);
  import cwm_pkg::*;

  localparam int PtrW = (MAILBOX_DEPTH > 1) ? $clog2(MAILBOX_DEPTH) : 1;
  localparam logic [PtrW-1:0] LastSlot = PtrW'(MAILBOX_DEPTH - 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StPut  = 2'd2;

  logic [1:0]      state;
  logic [3:0]      word_length;
  logic            match_on;
  logic            match_off;
  logic [PtrW-1:0] write_pointer;

  // slot memory and per-slot valid bits
  slot_t           mem [MAILBOX_DEPTH];
  logic            vld [MAILBOX_DEPTH];
  slot_t           mem_q;
  logic            vld_q;

  logic [PtrW-1:0] rd_addr;
  logic            chk_on;
  logic [PtrW-1:0] chk_addr;
  logic [1:0]      rid;
  logic            res_found;
  logic [1:0]      res_msg;

  logic            accept;
  logic            is_char;
  logic            is_end;
  logic            post;
  logic [1:0]      post_msg;
  slot_t           chk_slot;
  logic            chk_hit;
  logic            chk_last;
  logic            put_go;

  assign in_ready = (state == StIdle);
  assign accept   = in_valid && in_ready;
  assign is_char  = accept && (command == CmdChar);
  assign is_end   = is_char && (char_byte == EndMark);

  // dictionary decision at the end mark
  always_comb begin
    post     = 1'b0;
    post_msg = MsgNone;
    if (is_end) begin
      if (word_length == OnLen && match_on) begin
        post     = 1'b1;
        post_msg = MsgOn;
      end else if (word_length == OffLen && match_off) begin
        post     = 1'b1;
        post_msg = MsgOff;
      end
    end
  end

  // word building
  always_ff @(posedge clk) begin
    if (rst) begin
      word_length <= '0;
      match_on    <= 1'b1;
      match_off   <= 1'b1;
    end else if (is_end) begin
      word_length <= '0;
      match_on    <= 1'b1;
      match_off   <= 1'b1;
    end else if (is_char) begin
      if (!(word_length < OnLen && char_byte == on_char(word_length))) begin
        match_on <= 1'b0;
      end
      if (!(word_length < OffLen && char_byte == off_char(word_length))) begin
        match_off <= 1'b0;
      end
      if (word_length < LenMax) begin
        word_length <= word_length + 4'd1;
      end
    end
  end

  // write pointer wraps at the mailbox depth
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
    end else if (post) begin
      write_pointer <= (write_pointer == LastSlot) ? '0 : write_pointer + PtrW'(1);
    end
  end

  // slot memory: write on post, registered read for the scan
  always_ff @(posedge clk) begin
    if (post) begin
      mem[write_pointer] <= '{rcv: RcvLed, msg: post_msg};
    end
    mem_q <= mem[rd_addr];
  end

  // an invalid slot reads as receiver 0 / message 0
  assign chk_slot = vld_q ? mem_q : slot_t'{rcv: RcvNone, msg: MsgNone};
  assign chk_hit  = (state == StScan) && chk_on && (chk_slot.rcv == rid);
  assign chk_last = (chk_addr == LastSlot);

  // valid bits: set by a post, cleared by a retrieve hit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAILBOX_DEPTH; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      if (post) begin
        vld[write_pointer] <= 1'b1;
      end
      if (chk_hit) begin
        vld[chk_addr] <= 1'b0;
      end
    end
    vld_q <= vld[rd_addr];
  end

  assign put_go = (state == StPut) && (!out_valid || out_ready);

  // retrieve sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= StIdle;
      rd_addr <= '0;
      chk_on  <= 1'b0;
    end else begin
      case (state)
        StIdle: begin
          rd_addr <= '0;
          chk_on  <= 1'b0;
          if (accept && command == CmdGet) begin
            state <= StScan;
          end
        end
        StScan: begin
          chk_on <= 1'b1;
          if (rd_addr != LastSlot) begin
            rd_addr <= rd_addr + PtrW'(1);
          end
          if (chk_on && (chk_hit || chk_last)) begin
            state <= StPut;
          end
        end
        StPut: begin
          if (put_go) begin
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  // scan payload: receiver under search, address being checked, result
  always_ff @(posedge clk) begin
    if (accept) begin
      rid <= receiver_id;
    end
    chk_addr <= rd_addr;
    if (state == StScan && chk_on && (chk_hit || chk_last)) begin
      res_found <= chk_hit;
      res_msg   <= chk_hit ? chk_slot.msg : MsgNone;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (put_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_go) begin
      found        <= res_found;
      message_code <= res_msg;
    end
  end

endmodule

`default_nettype wire

>>> sv/cwm_checker.sv
`default_nettype none

module cwm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       command,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       found,
  input wire logic [1:0] message_code
);
  import cwm_pkg::*;

  // no result straight after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // a retrieve request keeps the block busy for the scan
  a_get_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && command == CmdGet) |=> !in_ready)
    else $error("request taken during a retrieve scan");

  // a miss carries the default message
  a_miss_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (message_code == MsgNone))
    else $error("miss with a message code");

  // only known message codes come out
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (message_code == MsgNone || message_code == MsgOn || message_code == MsgOff))
    else $error("unknown message code");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(found) && $stable(message_code)))
    else $error("stalled result changed");

endmodule

bind command_word_mailbox cwm_checker u_cwm_checker (.*);

`default_nettype wire

>>> tb/sv/command_word_mailbox_tb.sv
`default_nettype none

module command_word_mailbox_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cwm_pkg::*;

  localparam int Depth         = MailboxDepthDefault;
  localparam int TargetItems   = 1250;
  localparam int StallLimit    = 2000;
  localparam int HoldOffCycles = 300;
  localparam logic [47:0] OnWord  = "LED_ON";
  localparam logic [55:0] OffWord = "LED_OFF";

  typedef struct packed {
    logic       found;
    logic [1:0] msg;
  } mail_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       command = CmdChar;
  logic [7:0] char_byte = 8'h00;
  logic [1:0] receiver_id = RcvNone;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       found;
  logic [1:0] message_code;

  // predicted state of the word builder and the mailbox
  logic [3:0] word_len;
  logic       on_ok;
  logic       off_ok;
  logic [1:0] box_rcv [Depth];
  logic [1:0] box_msg [Depth];
  int         post_ptr;

  mail_result_t pending_results[$];
  logic [7:0]   word_buf[$];
  int items_sent       = 0;
  int mismatches       = 0;
  int idle_cycles      = 0;
  int hold_off_request = 0;
  bit steady           = 1'b0;

  command_word_mailbox #(.MAILBOX_DEPTH(Depth)) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .char_byte    (char_byte),
    .receiver_id  (receiver_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .message_code (message_code)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // dictionary letters, index 0 is the first character
  function automatic logic [7:0] on_letter(input int idx);
    return (idx < OnLen) ? OnWord[8*(OnLen-1-idx) +: 8] : 8'h00;
  endfunction

  function automatic logic [7:0] off_letter(input int idx);
    return (idx < OffLen) ? OffWord[8*(OffLen-1-idx) +: 8] : 8'h00;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic post_message(input logic [1:0] msg);
    box_rcv[post_ptr] = RcvLed;
    box_msg[post_ptr] = msg;
    post_ptr = (post_ptr + 1) % Depth;
  endtask

  // apply one accepted request to the predicted state, queue any result
  task automatic predict_request(input logic cmd, input logic [7:0] ch, input logic [1:0] rid);
    mail_result_t res;
    bit hit;
    if (cmd == CmdChar) begin
      if (ch == EndMark) begin
        if (word_len == OnLen && on_ok) post_message(MsgOn);
        else if (word_len == OffLen && off_ok) post_message(MsgOff);
        word_len = '0;
        on_ok = 1'b1;
        off_ok = 1'b1;
      end else begin
        if (!(word_len < OnLen && ch == on_letter(word_len))) on_ok = 1'b0;
        if (!(word_len < OffLen && ch == off_letter(word_len))) off_ok = 1'b0;
        if (word_len < LenMax) word_len = word_len + 4'd1;
      end
    end else begin
      res.found = 1'b0;
      res.msg = MsgNone;
      hit = 1'b0;
      // lowest slot holding the receiver wins and is cleared
      for (int i = 0; i < Depth; i++) begin
        if (!hit && box_rcv[i] == rid) begin
          hit = 1'b1;
          res.found = 1'b1;
          res.msg = box_msg[i];
          box_rcv[i] = RcvNone;
          box_msg[i] = MsgNone;
        end
      end
      pending_results.push_back(res);
    end
  endtask

  // offer one request, wait for acceptance, then maybe leave a gap
  task automatic send_request(input logic cmd, input logic [7:0] ch, input logic [1:0] rid);
    int gap;
    in_valid <= 1'b1;
    command <= cmd;
    char_byte <= ch;
    receiver_id <= rid;
    do @(posedge clk); while (in_ready !== 1'b1);
    predict_request(cmd, ch, rid);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_char(input logic [7:0] ch);
    send_request(CmdChar, ch, 2'($urandom_range(0, 3)));
  endtask

  task automatic send_get(input logic [1:0] rid);
    send_request(CmdGet, 8'($urandom_range(0, 255)), rid);
  endtask

  task automatic load_word(input bit use_off);
    word_buf.delete();
    if (use_off) for (int k = 0; k < OffLen; k++) word_buf.push_back(off_letter(k));
    else for (int k = 0; k < OnLen; k++) word_buf.push_back(on_letter(k));
  endtask

  // send the buffered word and its end mark, with retrieves now and then mid-word
  task automatic send_buffered_word(input int get_pct);
    foreach (word_buf[k]) begin
      if ($urandom_range(0, 99) < get_pct) send_get(RcvLed);
      send_char(word_buf[k]);
    end
    send_char(EndMark);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // exact LED_ON posts, then retrieve it
    load_word(1'b0);
    send_buffered_word(0);
    send_get(RcvLed);
    // LED_OFF with retrieves in the middle of the word
    load_word(1'b1);
    for (int i = 0; i < 5; i++) send_char(word_buf[i]);
    send_request(CmdGet, 8'hFF, 2'd2);
    // a retrieve carrying '*' must not end the word
    send_request(CmdGet, EndMark, 2'd3);
    send_char(word_buf[5]);
    send_char(word_buf[6]);
    send_char(EndMark);
    send_get(RcvLed);
    // mailbox empty again, receiver 0 hits the first empty slot
    send_get(RcvLed);
    send_get(RcvNone);
    // lone end mark, then a word of extreme bytes
    send_char(EndMark);
    send_request(CmdChar, 8'h00, 2'd3);
    send_request(CmdChar, 8'hFF, 2'd0);
    send_char(EndMark);
    send_get(RcvLed);
  endtask

  task automatic test_mailbox_wrap();
    // more posts than slots overwrite the oldest ones
    for (int n = 0; n < Depth + 2; n++) begin
      load_word(n[0]);
      send_buffered_word(0);
    end
    for (int n = 0; n < Depth + 2; n++) send_get(RcvLed);
    send_get(RcvNone);
  endtask

  task automatic test_output_hold();
    for (int n = 0; n < 4; n++) begin
      load_word(n[0]);
      send_buffered_word(0);
    end
    wait_for_drain();
    // receiver holds off while retrieves keep coming back to back
    hold_off_request = HoldOffCycles;
    steady = 1'b1;
    for (int n = 0; n < 12; n++) send_get((n % 3 == 2) ? RcvNone : RcvLed);
    steady = 1'b0;
    wait_for_drain();
  endtask

  task automatic test_random();
    int choice;
    int len;
    int pos;
    while (items_sent < TargetItems) begin
      if ($urandom_range(0, 99) < 2) steady = !steady;
      if ($urandom_range(0, 199) == 0) wait_for_drain();
      choice = $urandom_range(0, 99);
      if (choice < 25) begin
        load_word(1'b0);
        send_buffered_word(5);
      end else if (choice < 45) begin
        load_word(1'b1);
        send_buffered_word(5);
      end else if (choice < 55) begin
        // near miss of a dictionary word
        load_word(1'($urandom_range(0, 1)));
        pos = $urandom_range(0, word_buf.size() - 1);
        case ($urandom_range(0, 2))
          0:       word_buf[pos] = word_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
          1:       void'(word_buf.pop_back());
          default: word_buf.push_back(8'($urandom_range(0, 255)));
        endcase
        send_buffered_word(5);
      end else if (choice < 60) begin
        // overlong word, length counter saturates
        load_word(1'($urandom_range(0, 1)));
        len = $urandom_range(8, 24);
        while (word_buf.size() < len) word_buf.push_back(8'h41 + 8'($urandom_range(0, 25)));
        send_buffered_word(5);
      end else if (choice < 65) begin
        send_char(EndMark);
      end else if (choice < 73) begin
        len = $urandom_range(1, 8);
        repeat (len) send_char(8'($urandom_range(0, 255)));
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) send_get(($urandom_range(0, 99) < 75) ? RcvLed : 2'($urandom_range(0, 3)));
      end
    end
    steady = 1'b0;
  endtask

  // result receiver with random stalls and requested hold-offs
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left == 0 && hold_off_request > 0) begin
        stall_left = hold_off_request;
        hold_off_request = 0;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    mail_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no retrieve pending");
      end else begin
        want = pending_results.pop_front();
        if (found !== want.found)
          report_mismatch($sformatf("found %b, expected %b", found, want.found));
        if (message_code !== want.msg)
          report_mismatch($sformatf("message_code %0d, expected %0d", message_code, want.msg));
      end
    end
  end

  // stop a hung run
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("[command_word_mailbox] ERROR");
      $finish;
    end
  end

  initial begin : run
    word_len = '0;
    on_ok = 1'b1;
    off_ok = 1'b1;
    post_ptr = 0;
    for (int i = 0; i < Depth; i++) begin
      box_rcv[i] = RcvNone;
      box_msg[i] = MsgNone;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_mailbox_wrap();
    test_output_hold();
    test_random();
    wait_for_drain();
    repeat (Depth + 4) @(posedge clk);
    if (mismatches == 0) $display("[command_word_mailbox] OK");
    else $display("[command_word_mailbox] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
